// ===== design/sorted_deadline_timer_queue_core_defines.svh =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue - assertion macros
// Shared property wrappers for the timer queue RTL, clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SDTQ_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDTQ_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sdtq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue - package
// Sizes, mode codes, flag positions, beat and control types.
// ---------------------------------------------------------------------------
package sdtq_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int ID_W        = $clog2(TIMER_COUNT);
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
    localparam int MODE_W      = 3;
    localparam int TID_W       = 4;
    localparam int DELAY_W     = 48;
    localparam int TIME_W      = 64;
    localparam int FLAG_W      = 3;

    localparam logic [MODE_W-1:0] MODE_SCHED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

    localparam int FL_PEND  = 0;
    localparam int FL_FIRED = 1;
    localparam int FL_INVOK = 2;

    localparam logic [FLAG_W-1:0] FLAGS_SCHED = 3'b001;
    localparam logic [FLAG_W-1:0] FLAGS_FIRE  = 3'b110;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_INS,
        ST_EARLY,
        ST_RESP,
        ST_RUN_GATE,
        ST_RUN_CHK,
        ST_RUN_END
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TID_W-1:0]   timer_id;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  now_time;
    } t_in_beat;

    typedef struct packed {
        logic [TID_W-1:0] result_timer;
        logic             is_fire;
        logic             pending_flag;
        logic             fired_flag;
        logic             invoking_flag;
        logic             had_expired;
        logic             last;
    } t_out_beat;

    typedef struct packed {
        logic            rm;
        logic            ins;
        logic [ID_W-1:0] pos;
        logic [ID_W-1:0] id;
    } t_list_op;

endpackage

// ===== design/sorted_deadline_timer_queue_core.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue - top level
// Sixteen one-shot timers kept in a deadline-sorted list, walked by one
// shared 64-bit compare unit under a small sequencer.
// ---------------------------------------------------------------------------
// Sequencing: ack, query and bad ids go IDLE then RESP; stop passes FIND first
//   when the timer is pending; schedule walks FIND (when pending), INS and
//   EARLY before RESP; run goes RUN_GATE, then RUN_CHK when something is due,
//   then RUN_END. Output stalls hold RESP, RUN_CHK and RUN_END.
// Throughput: one item at a time; the input stalls until the sequencer is
//   back in idle. The list walk reads one entry per cycle through the shared
//   deadline comparator.
// Reset: synchronous, active low; clears all flags, list count, earliest
//   deadline and the sequencer. Deadlines and list slots are not cleared.
// ---------------------------------------------------------------------------
`include "sorted_deadline_timer_queue_core_defines.svh"

module sorted_deadline_timer_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sdtq_pkg::t_in_beat i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sdtq_pkg::t_out_beat o_out_data
);

    // -----------------------------------------------------------------------
    // State
    // -----------------------------------------------------------------------
    sdtq_pkg::t_state r_state, n_state;

    logic [sdtq_pkg::MODE_W-1:0] r_mode;
    logic [sdtq_pkg::TID_W-1:0]  r_tid;
    logic                        r_had;
    logic [sdtq_pkg::FLAG_W-1:0] r_rflags;       // flags to report for non-run items
    logic [sdtq_pkg::TIME_W-1:0] r_key;          // new deadline, or now for run

    logic [sdtq_pkg::CNT_W-1:0]  r_ptr, n_ptr;
    logic [sdtq_pkg::TIME_W-1:0] r_earliest, n_earliest;
    logic                        r_was_empty, n_was_empty;
    logic                        r_have, n_have; // fire beat held until we know if it is last
    logic [sdtq_pkg::ID_W-1:0]   r_held, n_held;

    sdtq_pkg::t_out_beat r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [sdtq_pkg::TIME_W-1:0] r_deadline [sdtq_pkg::TIMER_COUNT];
    logic [sdtq_pkg::FLAG_W-1:0] r_flags    [sdtq_pkg::TIMER_COUNT];

    // -----------------------------------------------------------------------
    // Combinational nets
    // -----------------------------------------------------------------------
    logic                        in_acc;
    logic                        out_free;
    logic [sdtq_pkg::ID_W-1:0]   acc_idx;
    logic                        acc_id_ok;
    logic [sdtq_pkg::FLAG_W-1:0] acc_flags;
    logic [sdtq_pkg::FLAG_W-1:0] acc_rflags;

    sdtq_pkg::t_list_op          list_op;
    logic [sdtq_pkg::ID_W-1:0]   rd_id;
    logic [sdtq_pkg::CNT_W-1:0]  list_count;
    logic [sdtq_pkg::TIME_W-1:0] dl_rd;

    logic [sdtq_pkg::TIME_W-1:0] cmp_lhs;
    logic                        cmp_le;

    logic                        flag_we;
    logic [sdtq_pkg::ID_W-1:0]   flag_wa;
    logic [sdtq_pkg::FLAG_W-1:0] flag_wd;

    logic [sdtq_pkg::TIMER_COUNT-1:0] pend_vec;

    // -----------------------------------------------------------------------
    // Handshake
    // -----------------------------------------------------------------------
    assign o_in_stall  = (r_state != sdtq_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Item addressed by the incoming beat
    assign acc_idx   = sdtq_pkg::ID_W'(i_in_data.timer_id);
    assign acc_id_ok = (32'(i_in_data.timer_id) < sdtq_pkg::TIMER_COUNT);
    assign acc_flags = r_flags[acc_idx];

    // -----------------------------------------------------------------------
    // Order list: one read port at the scan pointer
    // -----------------------------------------------------------------------
    sdtq_list u_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (list_op),
        .i_rd_pos (r_ptr[sdtq_pkg::ID_W-1:0]),
        .o_rd_id  (rd_id),
        .o_count  (list_count)
    );

    assign dl_rd = r_deadline[rd_id];

    // Shared compare unit: a stored deadline, or the earliest mark, against
    // the key (new deadline on schedule, current time on run).
    assign cmp_lhs = ((r_state == sdtq_pkg::ST_RUN_GATE) || (r_state == sdtq_pkg::ST_EARLY))
                     ? r_earliest : dl_rd;
    assign cmp_le  = (cmp_lhs <= r_key);

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_earliest  = r_earliest;
        n_was_empty = r_was_empty;
        n_have      = r_have;
        n_held      = r_held;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        list_op     = '0;
        flag_we     = 1'b0;
        flag_wa     = acc_idx;
        flag_wd     = acc_flags;
        acc_rflags  = acc_flags;

        unique case (r_state)
            sdtq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_ptr = '0;
                    if (i_in_data.mode == sdtq_pkg::MODE_RUN) begin
                        n_have  = 1'b0;
                        n_state = sdtq_pkg::ST_RUN_GATE;
                    end else if (!acc_id_ok) begin
                        acc_rflags = '0;
                        n_state    = sdtq_pkg::ST_RESP;
                    end else begin
                        unique case (i_in_data.mode)
                            sdtq_pkg::MODE_SCHED: begin
                                // final flags are known now: pending only
                                flag_we    = 1'b1;
                                flag_wd    = sdtq_pkg::FLAGS_SCHED;
                                acc_rflags = sdtq_pkg::FLAGS_SCHED;
                                n_state    = acc_flags[sdtq_pkg::FL_PEND]
                                             ? sdtq_pkg::ST_FIND : sdtq_pkg::ST_INS;
                            end
                            sdtq_pkg::MODE_STOP: begin
                                flag_we = 1'b1;
                                flag_wd = acc_flags;
                                flag_wd[sdtq_pkg::FL_PEND]  = 1'b0;
                                flag_wd[sdtq_pkg::FL_FIRED] = 1'b0;
                                acc_rflags = flag_wd;
                                n_state    = acc_flags[sdtq_pkg::FL_PEND]
                                             ? sdtq_pkg::ST_FIND : sdtq_pkg::ST_RESP;
                            end
                            sdtq_pkg::MODE_ACK: begin
                                flag_we = 1'b1;
                                flag_wd = acc_flags;
                                flag_wd[sdtq_pkg::FL_INVOK] = 1'b0;
                                acc_rflags = flag_wd;
                                n_state    = sdtq_pkg::ST_RESP;
                            end
                            default: begin
                                // query and unused codes: report only
                                n_state = sdtq_pkg::ST_RESP;
                            end
                        endcase
                    end
                end
            end

            sdtq_pkg::ST_FIND: begin
                // walk the list for this timer and pull it out
                if ((r_ptr < list_count) && (rd_id != sdtq_pkg::ID_W'(r_tid))) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    if (r_ptr < list_count) begin
                        list_op.rm  = 1'b1;
                        list_op.pos = r_ptr[sdtq_pkg::ID_W-1:0];
                    end
                    n_ptr   = '0;
                    n_state = (r_mode == sdtq_pkg::MODE_SCHED)
                              ? sdtq_pkg::ST_INS : sdtq_pkg::ST_RESP;
                end
            end

            sdtq_pkg::ST_INS: begin
                // advance past every entry due no later than the new deadline
                if ((r_ptr < list_count) && cmp_le) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    list_op.ins = 1'b1;
                    list_op.pos = r_ptr[sdtq_pkg::ID_W-1:0];
                    list_op.id  = sdtq_pkg::ID_W'(r_tid);
                    n_was_empty = (list_count == '0);
                    n_state     = sdtq_pkg::ST_EARLY;
                end
            end

            sdtq_pkg::ST_EARLY: begin
                if (r_was_empty || (r_earliest == '0) || !cmp_le) begin
                    n_earliest = r_key;
                end
                n_state = sdtq_pkg::ST_RESP;
            end

            sdtq_pkg::ST_RESP: begin
                if (out_free) begin
                    n_out.result_timer  = r_tid;
                    n_out.is_fire       = 1'b0;
                    n_out.pending_flag  = r_rflags[sdtq_pkg::FL_PEND];
                    n_out.fired_flag    = r_rflags[sdtq_pkg::FL_FIRED];
                    n_out.invoking_flag = r_rflags[sdtq_pkg::FL_INVOK];
                    n_out.had_expired   = r_had;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = sdtq_pkg::ST_IDLE;
                end
            end

            sdtq_pkg::ST_RUN_GATE: begin
                // nothing due when no mark is set or now is below it
                n_state = ((r_earliest == '0) || !cmp_le)
                          ? sdtq_pkg::ST_RUN_END : sdtq_pkg::ST_RUN_CHK;
            end

            sdtq_pkg::ST_RUN_CHK: begin
                if ((list_count != '0) && cmp_le) begin
                    if (!r_have || out_free) begin
                        if (r_have) begin
                            n_out.result_timer  = sdtq_pkg::TID_W'(r_held);
                            n_out.is_fire       = 1'b1;
                            n_out.pending_flag  = sdtq_pkg::FLAGS_FIRE[sdtq_pkg::FL_PEND];
                            n_out.fired_flag    = sdtq_pkg::FLAGS_FIRE[sdtq_pkg::FL_FIRED];
                            n_out.invoking_flag = sdtq_pkg::FLAGS_FIRE[sdtq_pkg::FL_INVOK];
                            n_out.had_expired   = 1'b0;
                            n_out.last          = 1'b0;
                            n_out_valid         = 1'b1;
                        end
                        // pop the head and mark it fired
                        list_op.rm  = 1'b1;
                        list_op.pos = '0;
                        flag_we     = 1'b1;
                        flag_wa     = rd_id;
                        flag_wd     = sdtq_pkg::FLAGS_FIRE;
                        n_held      = rd_id;
                        n_have      = 1'b1;
                    end
                end else begin
                    n_earliest = (list_count != '0) ? dl_rd : '0;
                    n_state    = sdtq_pkg::ST_RUN_END;
                end
            end

            sdtq_pkg::ST_RUN_END: begin
                if (out_free) begin
                    n_out.result_timer  = r_have ? sdtq_pkg::TID_W'(r_held) : '0;
                    n_out.is_fire       = r_have;
                    n_out.pending_flag  = 1'b0;
                    n_out.fired_flag    = r_have;
                    n_out.invoking_flag = r_have;
                    n_out.had_expired   = 1'b0;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = sdtq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdtq_pkg::ST_IDLE;
            r_earliest  <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_earliest  <= n_earliest;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_was_empty <= n_was_empty;
        r_held      <= n_held;
        r_out       <= n_out;
        if (in_acc) begin
            r_mode   <= i_in_data.mode;
            r_tid    <= i_in_data.timer_id;
            r_rflags <= acc_rflags;
            r_had    <= (i_in_data.mode == sdtq_pkg::MODE_STOP) && acc_id_ok
                        && acc_flags[sdtq_pkg::FL_FIRED];
            r_key    <= (i_in_data.mode == sdtq_pkg::MODE_RUN)
                        ? i_in_data.now_time
                        : i_in_data.now_time + sdtq_pkg::TIME_W'(i_in_data.delay);
        end
    end

    // Deadline store: written once per schedule, read at the list pointer
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.mode == sdtq_pkg::MODE_SCHED) && acc_id_ok) begin
            r_deadline[acc_idx] <= i_in_data.now_time
                                   + sdtq_pkg::TIME_W'(i_in_data.delay);
        end
    end

    // Flag store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sdtq_pkg::TIMER_COUNT; i++) begin
                r_flags[i] <= '0;
            end
        end else if (flag_we) begin
            r_flags[flag_wa] <= flag_wd;
        end
    end

    always_comb begin
        for (int i = 0; i < sdtq_pkg::TIMER_COUNT; i++) begin
            pend_vec[i] = r_flags[i][sdtq_pkg::FL_PEND];
        end
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `SDTQ_CHK_IMP(a_count_bound, 1'b1, list_count <= sdtq_pkg::CNT_W'(sdtq_pkg::TIMER_COUNT), "list count above timer count")
    `SDTQ_CHK_IMP(a_pend_match, r_state == sdtq_pkg::ST_IDLE, $countones(pend_vec) == int'(list_count), "pending flags disagree with list count")
    `SDTQ_CHK_IMP(a_ins_room, list_op.ins, list_count < sdtq_pkg::CNT_W'(sdtq_pkg::TIMER_COUNT), "insert into a full list")
    `SDTQ_CHK_NXT(a_busy_after_accept, in_acc, r_state != sdtq_pkg::ST_IDLE, "accepted beat left sequencer idle")

endmodule

// ===== design/sdtq_list.sv =====
// ---------------------------------------------------------------------------
// Sorted deadline timer queue - order list
// Holds timer ids in deadline order plus the fill count; removes or inserts
// one entry per cycle by shifting the tail, and reads one entry by position.
// ---------------------------------------------------------------------------
module sdtq_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdtq_pkg::t_list_op                i_op,
    input  logic [sdtq_pkg::ID_W-1:0]         i_rd_pos,
    output logic [sdtq_pkg::ID_W-1:0]         o_rd_id,
    output logic [sdtq_pkg::CNT_W-1:0]        o_count
);

    logic [sdtq_pkg::ID_W-1:0]  r_order [sdtq_pkg::TIMER_COUNT];
    logic [sdtq_pkg::CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op.rm) begin
            r_count <= r_count - 1'b1;
        end else if (i_op.ins) begin
            r_count <= r_count + 1'b1;
        end
    end

    for (genvar j = 0; j < sdtq_pkg::TIMER_COUNT; j++) begin : g_slot
        localparam int NX = (j + 1 < sdtq_pkg::TIMER_COUNT) ? j + 1 : j;
        localparam int PV = (j > 0) ? j - 1 : 0;

        // close the gap on remove, open one on insert
        always_ff @(posedge i_clk) begin
            if (i_op.rm && (sdtq_pkg::ID_W'(j) >= i_op.pos)) begin
                r_order[j] <= r_order[NX];
            end else if (i_op.ins && (sdtq_pkg::ID_W'(j) > i_op.pos)) begin
                r_order[j] <= r_order[PV];
            end else if (i_op.ins && (sdtq_pkg::ID_W'(j) == i_op.pos)) begin
                r_order[j] <= i_op.id;
            end
        end
    end

    assign o_rd_id = r_order[i_rd_pos];
    assign o_count = r_count;

endmodule

// ===== verif/sorted_deadline_timer_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted deadline timer queue - testbench
// Walks a short table of directed beats through the core, then a long run of
// random beats built around a moving clock. A local copy of the timer state
// predicts untyped beats' results. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module sorted_deadline_timer_queue_core_tb;

    // Mode codes above query have no name in the package; the core treats
    // them as query.
    localparam logic [sdtq_pkg::MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [sdtq_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [sdtq_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 410;

    localparam logic [sdtq_pkg::TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [sdtq_pkg::DELAY_W-1:0] DELAY_MAX = '1;

    typedef struct packed {
        sdtq_pkg::t_in_beat  beat;
        logic                typed;
        sdtq_pkg::t_out_beat want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    sdtq_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    sdtq_pkg::t_out_beat o_out_data;

    sorted_deadline_timer_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Timer state as the core should hold it
    // -----------------------------------------------------------------------
    logic [sdtq_pkg::TIME_W-1:0] tmr_deadline [sdtq_pkg::TIMER_COUNT];
    logic [sdtq_pkg::FLAG_W-1:0] tmr_flags    [sdtq_pkg::TIMER_COUNT];
    logic [sdtq_pkg::ID_W-1:0]   due_order    [sdtq_pkg::TIMER_COUNT];
    int                          due_count;
    logic [sdtq_pkg::TIME_W-1:0] earliest_due;

    sdtq_pkg::t_out_beat awaited_results[$];  // result beats not yet seen, oldest first
    sdtq_pkg::t_out_beat fresh_results[$];    // beats caused by the beat just accepted

    int                          errors;
    int                          idle_cycles;
    int                          calm_beats;
    logic [sdtq_pkg::TIME_W-1:0] sim_now;
    logic                        row_typed;
    sdtq_pkg::t_out_beat         row_want;
    t_dir_row                    plan[$];

    // Drop a timer from the sorted list and close the hole.
    function automatic void unlink_timer(input logic [sdtq_pkg::ID_W-1:0] id);
        for (int i = 0; i < due_count; i++) begin
            if (due_order[i] == id) begin
                for (int j = i; j + 1 < due_count; j++) due_order[j] = due_order[j + 1];
                due_count--;
                return;
            end
        end
    endfunction

    // Insert behind every timer due no later, so ties keep schedule order.
    function automatic void link_timer(input logic [sdtq_pkg::ID_W-1:0] id);
        int pos;
        pos = 0;
        if (due_count >= sdtq_pkg::TIMER_COUNT) return;
        while (pos < due_count && tmr_deadline[due_order[pos]] <= tmr_deadline[id]) pos++;
        for (int j = due_count; j > pos; j--) due_order[j] = due_order[j - 1];
        due_order[pos] = id;
        due_count++;
    endfunction

    // Advance the timer state by one input beat and collect its result beats.
    function automatic void compute_timer_results(input sdtq_pkg::t_in_beat b);
        logic [sdtq_pkg::ID_W-1:0] id;
        logic [sdtq_pkg::ID_W-1:0] head;
        logic                      had;
        logic                      was_empty;
        sdtq_pkg::t_out_beat       res;
        fresh_results.delete();
        had = 1'b0;
        if (b.mode == sdtq_pkg::MODE_RUN) begin
            // An earliest deadline of zero means nothing is armed.
            if (earliest_due != '0 && b.now_time >= earliest_due) begin
                while (due_count > 0) begin
                    head = due_order[0];
                    if (tmr_deadline[head] > b.now_time) break;
                    unlink_timer(head);
                    tmr_flags[head][sdtq_pkg::FL_PEND]  = 1'b0;
                    tmr_flags[head][sdtq_pkg::FL_FIRED] = 1'b1;
                    tmr_flags[head][sdtq_pkg::FL_INVOK] = 1'b1;
                    res               = '0;
                    res.result_timer  = head;
                    res.is_fire       = 1'b1;
                    res.pending_flag  = tmr_flags[head][sdtq_pkg::FL_PEND];
                    res.fired_flag    = tmr_flags[head][sdtq_pkg::FL_FIRED];
                    res.invoking_flag = tmr_flags[head][sdtq_pkg::FL_INVOK];
                    fresh_results.push_back(res);
                end
                earliest_due = (due_count > 0) ? tmr_deadline[due_order[0]] : '0;
            end
            if (fresh_results.size() == 0) begin
                res      = '0;
                res.last = 1'b1;
                fresh_results.push_back(res);
            end else begin
                res      = fresh_results.pop_back();
                res.last = 1'b1;
                fresh_results.push_back(res);
            end
            return;
        end

        if (int'(b.timer_id) >= sdtq_pkg::TIMER_COUNT) begin
            res              = '0;
            res.result_timer = b.timer_id;
            res.last         = 1'b1;
            fresh_results.push_back(res);
            return;
        end
        id = sdtq_pkg::ID_W'(b.timer_id);

        case (b.mode)
            sdtq_pkg::MODE_SCHED: begin
                if (tmr_flags[id][sdtq_pkg::FL_PEND]) unlink_timer(id);
                was_empty = (due_count == 0);
                tmr_flags[id][sdtq_pkg::FL_FIRED] = 1'b0;
                tmr_flags[id][sdtq_pkg::FL_INVOK] = 1'b0;
                tmr_deadline[id] = b.now_time
                                   + {{(sdtq_pkg::TIME_W - sdtq_pkg::DELAY_W){1'b0}}, b.delay};
                link_timer(id);
                if (was_empty || earliest_due == '0 || tmr_deadline[id] < earliest_due)
                    earliest_due = tmr_deadline[id];
                tmr_flags[id][sdtq_pkg::FL_PEND] = 1'b1;
            end
            sdtq_pkg::MODE_STOP: begin
                if (tmr_flags[id][sdtq_pkg::FL_PEND]) unlink_timer(id);
                had = tmr_flags[id][sdtq_pkg::FL_FIRED];
                tmr_flags[id][sdtq_pkg::FL_PEND]  = 1'b0;
                tmr_flags[id][sdtq_pkg::FL_FIRED] = 1'b0;
            end
            sdtq_pkg::MODE_ACK: begin
                tmr_flags[id][sdtq_pkg::FL_INVOK] = 1'b0;
            end
            default: ;
        endcase
        res               = '0;
        res.result_timer  = b.timer_id;
        res.pending_flag  = tmr_flags[id][sdtq_pkg::FL_PEND];
        res.fired_flag    = tmr_flags[id][sdtq_pkg::FL_FIRED];
        res.invoking_flag = tmr_flags[id][sdtq_pkg::FL_INVOK];
        res.had_expired   = had;
        res.last          = 1'b1;
        fresh_results.push_back(res);
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic sdtq_pkg::t_in_beat beat_of(
        input logic [sdtq_pkg::MODE_W-1:0]  mode,
        input logic [sdtq_pkg::TID_W-1:0]   tid,
        input logic [sdtq_pkg::DELAY_W-1:0] delay,
        input logic [sdtq_pkg::TIME_W-1:0]  now);
        sdtq_pkg::t_in_beat b;
        b.mode     = mode;
        b.timer_id = tid;
        b.delay    = delay;
        b.now_time = now;
        return b;
    endfunction

    // Single non-fire result beat, the only kind typed into the table.
    function automatic sdtq_pkg::t_out_beat out_beat(
        input logic [sdtq_pkg::TID_W-1:0]  tid,
        input logic [sdtq_pkg::FLAG_W-1:0] flags,
        input logic                        had);
        sdtq_pkg::t_out_beat r;
        r               = '0;
        r.result_timer  = tid;
        r.pending_flag  = flags[sdtq_pkg::FL_PEND];
        r.fired_flag    = flags[sdtq_pkg::FL_FIRED];
        r.invoking_flag = flags[sdtq_pkg::FL_INVOK];
        r.had_expired   = had;
        r.last          = 1'b1;
        return r;
    endfunction

    task automatic add_row(input sdtq_pkg::t_in_beat beat, input logic typed = 1'b0,
                           input sdtq_pkg::t_out_beat want = '0);
        t_dir_row row;
        row.beat  = beat;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Mostly back-to-back, some short gaps, a few long ones, and now and
    // then a calm stretch with no gap at all.
    function automatic int pick_gap();
        int r;
        if (calm_beats > 0) begin
            calm_beats--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_beats = $urandom_range(10, 30);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random beat around a moving clock: mostly well-formed schedule and run
    // traffic with small delays so timers actually fire, plus some noise.
    function automatic sdtq_pkg::t_in_beat roll_beat();
        sdtq_pkg::t_in_beat b;
        int                 pick;
        logic [63:0]        wide;
        logic [127:0]       raw;
        if ($urandom_range(0, 59) == 0) begin
            // Jump the clock: near the wrap point, anywhere, or back near zero.
            case ($urandom_range(0, 2))
                0:       sim_now = TIME_MAX - sdtq_pkg::TIME_W'($urandom_range(0, 400));
                1:       sim_now = {$urandom(), $urandom()};
                default: sim_now = sdtq_pkg::TIME_W'($urandom_range(0, 100));
            endcase
        end else begin
            sim_now = sim_now + sdtq_pkg::TIME_W'($urandom_range(0, 40));
        end
        b.mode     = sdtq_pkg::MODE_QUERY;
        b.timer_id = sdtq_pkg::TID_W'($urandom_range(0, sdtq_pkg::TIMER_COUNT - 1));
        b.delay    = sdtq_pkg::DELAY_W'($urandom_range(0, 300));
        b.now_time = sim_now;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            b.mode = sdtq_pkg::MODE_SCHED;
            if ($urandom_range(0, 19) == 0) begin
                wide    = {$urandom(), $urandom()};
                b.delay = wide[sdtq_pkg::DELAY_W-1:0];
            end
        end else if (pick < 65) begin
            b.mode = sdtq_pkg::MODE_RUN;
        end else if (pick < 75) begin
            b.mode = sdtq_pkg::MODE_STOP;
        end else if (pick < 85) begin
            b.mode = sdtq_pkg::MODE_ACK;
        end else if (pick < 92) begin
            b.mode = sdtq_pkg::MODE_QUERY;
        end else if (pick < 96) begin
            b.mode = sdtq_pkg::MODE_W'($urandom_range(int'(MODE_SPARE5), int'(MODE_SPARE7)));
        end else begin
            // Noise: every field fully random.
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            b   = raw[$bits(sdtq_pkg::t_in_beat)-1:0];
        end
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until accepted. Valid
    // stays high on return so a following beat can go out back to back.
    task automatic send_beat(input sdtq_pkg::t_in_beat beat, input logic typed,
                             input sdtq_pkg::t_out_beat want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        row_typed   = typed;
        row_want    = want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold the sender until every awaited beat has arrived.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Scoreboard: predict on every accepted input beat, compare every
    // accepted output beat against the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        sdtq_pkg::t_out_beat want;
        logic                moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            moved = 1'b1;
            compute_timer_results(i_in_data);
            if (row_typed) awaited_results.push_back(row_want);
            else foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing awaited: timer %0d fire %0b last %0b",
                       o_out_data.result_timer, o_out_data.is_fire, o_out_data.last);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_timer", want.result_timer, o_out_data.result_timer);
                check_field("is_fire", 4'(want.is_fire), 4'(o_out_data.is_fire));
                check_field("pending_flag", 4'(want.pending_flag), 4'(o_out_data.pending_flag));
                check_field("fired_flag", 4'(want.fired_flag), 4'(o_out_data.fired_flag));
                check_field("invoking_flag", 4'(want.invoking_flag),
                            4'(o_out_data.invoking_flag));
                check_field("had_expired", 4'(want.had_expired), 4'(o_out_data.had_expired));
                check_field("last", 4'(want.last), 4'(o_out_data.last));
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // End the run if no beat moves on either side for too long.
    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Receiver stall: short bursts mostly, a few long holds, quiet stretches.
    initial begin : out_stall_gen
        int   r;
        int   len;
        logic level;
        i_out_stall = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                level = 1'b0;
                len   = $urandom_range(1, 6);
            end else if (r < 65) begin
                level = 1'b0;
                len   = $urandom_range(20, 60);
            end else if (r < 95) begin
                level = 1'b1;
                len   = $urandom_range(1, 3);
            end else begin
                level = 1'b1;
                len   = $urandom_range(15, 50);
            end
            repeat (len) begin
                @(negedge i_clk);
                i_out_stall <= level;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        row_typed  = 1'b0;
        row_want   = '0;
        sim_now    = '0;
        calm_beats = 0;
        for (int i = 0; i < sdtq_pkg::TIMER_COUNT; i++) begin
            tmr_deadline[i] = '0;
            tmr_flags[i]    = '0;
            due_order[i]    = '0;
        end
        due_count    = 0;
        earliest_due = '0;

        // After reset nothing is pending, fired or invoking.
        add_row(beat_of(sdtq_pkg::MODE_QUERY, 4'd0, 48'd0, 64'd0), 1'b1,
                out_beat(4'd0, '0, 1'b0));
        // Run on an empty queue at the top of the time range.
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd15, DELAY_MAX, TIME_MAX), 1'b1,
                out_beat(4'd0, '0, 1'b0));
        add_row(beat_of(sdtq_pkg::MODE_STOP, 4'd15, 48'd0, 64'd0), 1'b1,
                out_beat(4'd15, '0, 1'b0));
        add_row(beat_of(sdtq_pkg::MODE_ACK, 4'd7, 48'd0, 64'd0), 1'b1,
                out_beat(4'd7, '0, 1'b0));
        // Two timers share a deadline, one is earlier, one takes the largest delay.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd3, 48'd100, 64'd1000), 1'b1,
                out_beat(4'd3, sdtq_pkg::FLAGS_SCHED, 1'b0));
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd5, 48'd100, 64'd1000), 1'b1,
                out_beat(4'd5, sdtq_pkg::FLAGS_SCHED, 1'b0));
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd1, 48'd50, 64'd1000), 1'b1,
                out_beat(4'd1, sdtq_pkg::FLAGS_SCHED, 1'b0));
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd9, DELAY_MAX, 64'd1000), 1'b1,
                out_beat(4'd9, sdtq_pkg::FLAGS_SCHED, 1'b0));
        // One tick short of the earliest deadline: nothing due.
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, 64'd1049), 1'b1,
                out_beat(4'd0, '0, 1'b0));
        // Fire 1, then the tie 3 and 5 in the order they were scheduled.
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, 64'd1100));
        add_row(beat_of(sdtq_pkg::MODE_QUERY, 4'd3, 48'd0, 64'd0));
        add_row(beat_of(sdtq_pkg::MODE_ACK, 4'd3, 48'd0, 64'd0));
        // Stop a fired timer: its fired flag comes back as had_expired.
        add_row(beat_of(sdtq_pkg::MODE_STOP, 4'd5, 48'd0, 64'd0));
        // Re-arm a pending timer with a much earlier deadline.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd9, 48'd10, 64'd2000));
        // Deadline wraps to exactly zero, which clears the earliest deadline.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd12, 48'd16, TIME_MAX - 64'd15));
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, 64'd3000), 1'b1,
                out_beat(4'd0, '0, 1'b0));
        // A later schedule re-arms the queue; 12, 9 and 2 then fire together.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd2, 48'd5, 64'd3000));
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, 64'd3005));
        // Deadline near the top of the range, fired at the largest time.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd14, 48'd16, TIME_MAX - 64'd255));
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, TIME_MAX));
        // Spare mode codes behave as query.
        add_row(beat_of(MODE_SPARE5, 4'd14, 48'd0, 64'd0));
        add_row(beat_of(MODE_SPARE6, 4'd10, DELAY_MAX, TIME_MAX));
        add_row(beat_of(MODE_SPARE7, 4'd3, 48'd0, 64'd0));
        // Zero deadline on an empty queue stays unarmed until the next schedule.
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd0, 48'd0, 64'd0));
        add_row(beat_of(sdtq_pkg::MODE_SCHED, 4'd15, 48'd1, 64'd0));
        add_row(beat_of(sdtq_pkg::MODE_RUN, 4'd0, 48'd0, 64'd1));

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_beat(plan[k].beat, plan[k].typed, plan[k].want);
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 99) hold_until_drained();
            send_beat(roll_beat(), 1'b0, '0);
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sorted_deadline_timer_queue_core.f =====
+incdir+design
design/sdtq_pkg.sv
design/sdtq_list.sv
design/sorted_deadline_timer_queue_core.sv
verif/sorted_deadline_timer_queue_core_tb.sv
